// ===== sv/rot_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rot_pkg
// Shared types and constants for the image rotation engine.
// ============================================================================
package rot_pkg;

    // Pixel channel width and default buffer dimension
    localparam int PIX_W       = 8;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int MAX_DIM_DEF = 128;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd2;

    // Rotation modes; the unused code behaves as 180
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_CW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CCW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_180 = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 8'd1;

    // Input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDATA
    } rot_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;     // capture accepted transaction
        logic exec;      // access frame store, advance position
        logic load_out;  // move read data into output register
    } rot_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_read;
    } rot_status_t;

endpackage

// ===== sv/rot_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rot_in_if / rot_out_if
// Valid/ready channels carrying the command stream and the rotated pixels.
// ============================================================================
interface rot_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [rot_pkg::PIX_W-1:0] in_red;
    logic [rot_pkg::PIX_W-1:0] in_green;
    logic [rot_pkg::PIX_W-1:0] in_blue;

    modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface rot_out_if;
    logic                      valid;
    logic                      ready;
    logic [rot_pkg::PIX_W-1:0] out_red;
    logic [rot_pkg::PIX_W-1:0] out_green;
    logic [rot_pkg::PIX_W-1:0] out_blue;
    logic                      last_pixel;

    modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

// ===== sv/rot_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rot_ctrl
// Sequencer: accept a transaction, run the frame store access, deliver.
// ============================================================================
module rot_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rot_pkg::rot_status_t status,
    output rot_pkg::rot_cmd_t    cmd
);

    rot_pkg::rot_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rot_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = rot_pkg::ST_EXEC;
            end
            rot_pkg::ST_EXEC:
            begin
                state_next = status.is_read ? rot_pkg::ST_RDATA : rot_pkg::ST_IDLE;
            end
            rot_pkg::ST_RDATA:
            begin
                if (out_free)
                    state_next = rot_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rot_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.latch    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            rot_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            rot_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            rot_pkg::ST_RDATA:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Hold the result until taken; refill straight from read data
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rot_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/rot_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rot_datapath
// Configuration, load/read positions, address mapping and the frame store.
// ============================================================================
module rot_datapath
#(
    parameter int MAX_DIM = rot_pkg::MAX_DIM_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rot_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_cmd,
    input  logic [rot_pkg::RGB_W-1:0]      in_pix,
    input  rot_pkg::rot_cmd_t              cmd,
    output rot_pkg::rot_status_t           status,
    output logic [rot_pkg::RGB_W-1:0]      out_pix,
    output logic                           out_last
);

    localparam int DW     = $clog2(MAX_DIM);
    localparam int EW     = DW + 1;
    localparam int AW     = 2 * DW;
    localparam int DEPTH  = 1 << AW;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_DIM);
    localparam logic [EW-1:0] ONE_E = EW'(1);

    // Configuration registers
    logic [rot_pkg::MODE_W-1:0]     mode_reg;
    logic [rot_pkg::CFG_DATA_W-1:0] rows_cfg_reg;
    logic [rot_pkg::CFG_DATA_W-1:0] cols_cfg_reg;

    // Captured transaction
    logic                      cmd_reg;
    logic [rot_pkg::RGB_W-1:0] pix_reg;

    // Positions
    logic [DW-1:0] load_row_reg, load_row_next;
    logic [DW-1:0] load_col_reg, load_col_next;
    logic [DW-1:0] read_row_reg, read_row_next;
    logic [DW-1:0] read_col_reg, read_col_next;

    // Frame store and read side
    logic [rot_pkg::RGB_W-1:0] frame_mem [DEPTH];
    logic [rot_pkg::RGB_W-1:0] rdata_reg;
    logic                      last_reg;
    logic [rot_pkg::RGB_W-1:0] out_pix_reg;
    logic                      out_last_reg;

    logic [EW-1:0] n_dim, m_dim, o_rows, o_cols;
    logic [DW-1:0] lr, lc, rr, rc, sr, sc;
    logic [EW-1:0] col_inc, row_inc;
    logic [DW-1:0] adv_row, adv_col, cur_row, cur_col;
    logic [EW-1:0] adv_rows, adv_cols;
    logic [AW-1:0] addr;
    logic          mem_we, last_now;
    logic          is_quarter;

    assign status.is_read = cmd_reg;
    assign out_pix        = out_pix_reg;
    assign out_last       = out_last_reg;

    // Clamp a size register to 1..MAX_DIM
    function automatic logic [EW-1:0] eff_dim(input logic [rot_pkg::CFG_DATA_W-1:0] v);
        logic [EW-1:0] r;
        if (v == '0)
            r = ONE_E;
        else if (int'(v) > MAX_DIM)
            r = MAX_E;
        else
            r = EW'(v);
        return r;
    endfunction

    assign n_dim      = eff_dim(rows_cfg_reg);
    assign m_dim      = eff_dim(cols_cfg_reg);
    assign is_quarter = (mode_reg == rot_pkg::MODE_CW) || (mode_reg == rot_pkg::MODE_CCW);
    assign o_rows     = is_quarter ? m_dim : n_dim;
    assign o_cols     = is_quarter ? n_dim : m_dim;

    // Drop stale positions back to the origin
    always_comb
    begin
        if (({1'b0, load_row_reg} >= n_dim) || ({1'b0, load_col_reg} >= m_dim))
        begin
            lr = '0;
            lc = '0;
        end
        else
        begin
            lr = load_row_reg;
            lc = load_col_reg;
        end
        if (({1'b0, read_row_reg} >= o_rows) || ({1'b0, read_col_reg} >= o_cols))
        begin
            rr = '0;
            rc = '0;
        end
        else
        begin
            rr = read_row_reg;
            rc = read_col_reg;
        end
    end

    // Map rotated position to source position
    always_comb
    begin
        case (mode_reg)
            rot_pkg::MODE_CW:
            begin
                sr = DW'(n_dim - ONE_E - {1'b0, rc});
                sc = rr;
            end
            rot_pkg::MODE_CCW:
            begin
                sr = rc;
                sc = DW'(m_dim - ONE_E - {1'b0, rr});
            end
            default:
            begin
                sr = DW'(n_dim - ONE_E - {1'b0, rr});
                sc = DW'(m_dim - ONE_E - {1'b0, rc});
            end
        endcase
    end

    assign last_now = ({1'b0, rr} == o_rows - ONE_E) && ({1'b0, rc} == o_cols - ONE_E);
    assign addr     = (cmd_reg == rot_pkg::CMD_READ) ? {sr, sc} : {lr, lc};
    assign mem_we   = cmd.exec && (cmd_reg == rot_pkg::CMD_LOAD);

    // Advance whichever position this transaction uses, row-major with wrap
    assign cur_row  = (cmd_reg == rot_pkg::CMD_READ) ? rr : lr;
    assign cur_col  = (cmd_reg == rot_pkg::CMD_READ) ? rc : lc;
    assign adv_rows = (cmd_reg == rot_pkg::CMD_READ) ? o_rows : n_dim;
    assign adv_cols = (cmd_reg == rot_pkg::CMD_READ) ? o_cols : m_dim;
    assign col_inc  = {1'b0, cur_col} + ONE_E;
    assign row_inc  = {1'b0, cur_row} + ONE_E;

    always_comb
    begin
        adv_row = cur_row;
        adv_col = DW'(col_inc);
        if (col_inc >= adv_cols)
        begin
            adv_col = '0;
            adv_row = (row_inc >= adv_rows) ? '0 : DW'(row_inc);
        end
    end

    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        read_row_next = read_row_reg;
        read_col_next = read_col_reg;
        if (cmd.exec)
        begin
            if (cmd_reg == rot_pkg::CMD_READ)
            begin
                read_row_next = adv_row;
                read_col_next = adv_col;
            end
            else
            begin
                load_row_next = adv_row;
                load_col_next = adv_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rot_pkg::MODE_CW;
            rows_cfg_reg <= rot_pkg::DIM_RESET;
            cols_cfg_reg <= rot_pkg::DIM_RESET;
            load_row_reg <= '0;
            load_col_reg <= '0;
            read_row_reg <= '0;
            read_col_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rot_pkg::REG_ROTATE_MODE: mode_reg     <= cfg_data[rot_pkg::MODE_W-1:0];
                    rot_pkg::REG_IMAGE_ROWS:  rows_cfg_reg <= cfg_data;
                    rot_pkg::REG_IMAGE_COLS:  cols_cfg_reg <= cfg_data;
                    default:                  mode_reg     <= mode_reg;
                endcase
            end
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            read_row_reg <= read_row_next;
            read_col_reg <= read_col_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= in_cmd;
            pix_reg <= in_pix;
        end
        if (cmd.exec)
            last_reg <= last_now;
        if (cmd.load_out)
        begin
            out_pix_reg  <= rdata_reg;
            out_last_reg <= last_reg;
        end
    end

    // Frame store: one write or one registered read per transaction
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[addr] <= pix_reg;
        if (cmd.exec)
            rdata_reg <= frame_mem[addr];
    end

endmodule

// ===== sv/image_rotation_engine.sv =====
`timescale 1ns / 1ps
// ============================================================================
// image_rotation_engine
// Frame-buffer rotator for RGB images: 90 CW, 90 CCW and 180 degrees.
// ============================================================================
// Usage:
//   in_ch carries one command per transaction. A load (cmd 0) writes the next
//   source pixel in row-major order; a read (cmd 1) returns the next pixel of
//   the rotated image in row-major order on out_ch, with last_pixel set on
//   the final pixel of the frame. Both positions wrap after a full image.
//   Program rotate_mode, image_rows and image_cols through the cfg_* write
//   port while no transaction is in flight; a position left outside the new
//   image restarts at the origin.
// Timing:
//   Each transaction is accepted in IDLE and makes one frame store access in
//   EXEC; a read then moves the registered memory output into the output
//   register in RDATA. The controller sequences these states around the
//   single-port frame store. The output register lets a new transaction be
//   accepted while a result waits; a read that finds the output still
//   stalled holds in its data cycle until the receiver takes the pending
//   pixel.
// Reset:
//   rst_n clears positions, config (mode CW, 1x1 image) and the handshake
//   state. Frame store contents are undefined until loaded; no clearing pass.
// ============================================================================
module image_rotation_engine
#(
    parameter int MAX_DIM = rot_pkg::MAX_DIM_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    rot_in_if.sink                         in_ch,
    rot_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [rot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rot_pkg::CFG_DATA_W-1:0] cfg_data
);

    rot_pkg::rot_cmd_t         dp_cmd;
    rot_pkg::rot_status_t      dp_status;
    logic [rot_pkg::RGB_W-1:0] in_pix;
    logic [rot_pkg::RGB_W-1:0] out_pix;

    // Pack red in the low byte, blue in the high byte
    assign in_pix = {in_ch.in_blue, in_ch.in_green, in_ch.in_red};

    assign out_ch.out_red   = out_pix[rot_pkg::PIX_W-1:0];
    assign out_ch.out_green = out_pix[2*rot_pkg::PIX_W-1:rot_pkg::PIX_W];
    assign out_ch.out_blue  = out_pix[3*rot_pkg::PIX_W-1:2*rot_pkg::PIX_W];

    // Sequence each transaction through capture, access and delivery
    rot_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // Hold config, positions and the frame store
    rot_datapath #(.MAX_DIM(MAX_DIM)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (in_ch.cmd),
        .in_pix    (in_pix),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .out_pix   (out_pix),
        .out_last  (out_ch.last_pixel)
    );

endmodule

// ===== sv/rot_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rot_checker
// Port-level checks on transaction timing of the image rotation engine.
// ============================================================================
module rot_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      in_cmd,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [rot_pkg::PIX_W-1:0] out_red,
    input logic [rot_pkg::PIX_W-1:0] out_green,
    input logic [rot_pkg::PIX_W-1:0] out_blue,
    input logic                      out_last
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // One transaction at a time: input closes after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    // A load produces no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_cmd == rot_pkg::CMD_LOAD && !out_valid) |=> !out_valid ##1 !out_valid)
        else $error("result appeared after a load");

    // A read into an empty output delivers its result after EXEC and RDATA
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_cmd == rot_pkg::CMD_READ && !out_valid) |-> ##3 out_valid)
        else $error("read result missing");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_red) && $stable(out_green)
            && $stable(out_blue) && $stable(out_last))
        else $error("stalled result changed");

endmodule

bind image_rotation_engine rot_checker u_rot_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_red   (out_ch.out_red),
    .out_green (out_ch.out_green),
    .out_blue  (out_ch.out_blue),
    .out_last  (out_ch.last_pixel)
);
